>>> rtl/lfpc_pkg.sv
// Shared types and constants for the line follower PWM controller.
package lfpc_pkg;

  localparam int DataW = 8;
  localparam int CfgIdxW = 3;

  localparam logic ModeTick = 1'b0;
  localparam logic ModeSample = 1'b1;

  localparam logic [1:0] SideNone = 2'd0;
  localparam logic [1:0] SideLeft = 2'd1;
  localparam logic [1:0] SideRight = 2'd2;
  localparam logic [1:0] SideBoth = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold     = 3'd0,
    CfgControlPeriod = 3'd1,
    CfgAdcPeriod     = 3'd2,
    CfgPwmPeriod     = 3'd3,
    CfgStraightDuty  = 3'd4,
    CfgFastDuty      = 3'd5,
    CfgSlowDuty      = 3'd6
  } lfpc_cfg_idx_t;

  typedef struct packed {
    logic             mode;
    logic [DataW-1:0] left_sample;
    logic [DataW-1:0] right_sample;
  } lfpc_item_t;

  typedef struct packed {
    logic             left_motor_on;
    logic             right_motor_on;
    logic             sample_request;
    logic [1:0]       line_state;
    logic [DataW-1:0] left_average;
    logic [DataW-1:0] right_average;
  } lfpc_result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [DataW-1:0]   wdata;
  } lfpc_cfg_req_t;

  typedef struct packed {
    logic [DataW-1:0] threshold;
    logic [DataW-1:0] control_period;
    logic [DataW-1:0] adc_period;
    logic [DataW-1:0] pwm_period;
    logic [DataW-1:0] straight_duty;
    logic [DataW-1:0] fast_duty;
    logic [DataW-1:0] slow_duty;
  } lfpc_cfg_t;

  localparam lfpc_cfg_t CfgReset = '{
    threshold:      8'd150,
    control_period: 8'd10,
    adc_period:     8'd2,
    pwm_period:     8'd255,
    straight_duty:  8'd255,
    fast_duty:      8'd200,
    slow_duty:      8'd50
  };

  localparam logic [1:0] SideReset = SideBoth;

endpackage

>>> rtl/lfpc_chan_if.sv
// Valid/ready channel carrying one request of payload type T.
interface lfpc_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/lfpc_core.sv
// Sample rings, averaging, classification, timing counters and PWM compare.
module lfpc_core #(
  parameter int AVG_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lfpc_pkg::lfpc_cfg_t    cfg_regs,
  input  logic                   take,
  input  lfpc_pkg::lfpc_item_t   item,
  output lfpc_pkg::lfpc_result_t result
);

  localparam int LogN = $clog2(AVG_COUNT);
  localparam int PtrW = (AVG_COUNT > 1) ? LogN : 1;
  localparam int SumW = lfpc_pkg::DataW + LogN;
  localparam int Shift = SumW + LogN;
  localparam int RecipW = Shift + 1;
  localparam int ProdW = SumW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << Shift) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));
  localparam logic [PtrW-1:0] PtrLast = PtrW'(AVG_COUNT - 1);

  logic [lfpc_pkg::DataW-1:0] left_ring [AVG_COUNT];
  logic [lfpc_pkg::DataW-1:0] right_ring [AVG_COUNT];
  logic [PtrW-1:0]            ring_pointer;
  logic [lfpc_pkg::DataW-1:0] adc_tick_count;
  logic [lfpc_pkg::DataW-1:0] control_tick_count;
  logic [lfpc_pkg::DataW-1:0] pwm_counter;
  logic [1:0]                 side_black;
  logic [1:0]                 motor_bits;
  logic [lfpc_pkg::DataW-1:0] left_average;
  logic [lfpc_pkg::DataW-1:0] right_average;

  logic [PtrW-1:0]            ring_pointer_next;
  logic [SumW-1:0]            left_sum, right_sum;
  logic [ProdW-1:0]           left_prod, right_prod;
  logic [lfpc_pkg::DataW-1:0] left_avg_now, right_avg_now;
  logic [lfpc_pkg::DataW-1:0] adc_inc, ctl_inc, pwm_inc;
  logic                       adc_fire, ctl_fire, tie;
  logic [1:0]                 side_black_next;
  logic [lfpc_pkg::DataW-1:0] left_average_next, right_average_next;
  logic [lfpc_pkg::DataW-1:0] duty_left, duty_right;
  logic [1:0]                 motor_bits_next;
  logic [lfpc_pkg::DataW-1:0] adc_tick_count_next, control_tick_count_next, pwm_counter_next;
  logic                       is_tick;

  always_comb begin
    left_sum = '0;
    right_sum = '0;
    for (int i = 0; i < AVG_COUNT; i++) begin
      left_sum = left_sum + SumW'(left_ring[i]);
      right_sum = right_sum + SumW'(right_ring[i]);
    end
  end

  assign left_prod = ProdW'(left_sum) * ProdW'(Recip);
  assign right_prod = ProdW'(right_sum) * ProdW'(Recip);
  assign left_avg_now = left_prod[Shift +: lfpc_pkg::DataW];
  assign right_avg_now = right_prod[Shift +: lfpc_pkg::DataW];

  assign ring_pointer_next = (ring_pointer == PtrLast) ? '0 : ring_pointer + PtrW'(1);
  assign is_tick = (item.mode == lfpc_pkg::ModeTick);

  assign adc_inc = adc_tick_count + 8'd1;
  assign adc_fire = (adc_inc >= cfg_regs.adc_period);
  assign adc_tick_count_next = adc_fire ? '0 : adc_inc;

  assign ctl_inc = control_tick_count + 8'd1;
  assign ctl_fire = (ctl_inc >= cfg_regs.control_period);
  assign control_tick_count_next = ctl_fire ? '0 : ctl_inc;

  assign tie = (left_avg_now == cfg_regs.threshold) || (right_avg_now == cfg_regs.threshold);
  assign side_black_next = (ctl_fire && !tie) ?
    {right_avg_now > cfg_regs.threshold, left_avg_now > cfg_regs.threshold} : side_black;
  assign left_average_next = ctl_fire ? left_avg_now : left_average;
  assign right_average_next = ctl_fire ? right_avg_now : right_average;

  always_comb begin
    unique case (side_black_next)
      lfpc_pkg::SideNone: begin
        duty_left = cfg_regs.straight_duty;
        duty_right = cfg_regs.straight_duty;
      end
      lfpc_pkg::SideLeft: begin
        duty_left = cfg_regs.fast_duty;
        duty_right = cfg_regs.slow_duty;
      end
      lfpc_pkg::SideRight: begin
        duty_left = cfg_regs.slow_duty;
        duty_right = cfg_regs.fast_duty;
      end
      lfpc_pkg::SideBoth: begin
        duty_left = '0;
        duty_right = '0;
      end
      default: begin
        duty_left = '0;
        duty_right = '0;
      end
    endcase
  end

  assign motor_bits_next = {pwm_counter < duty_right, pwm_counter < duty_left};
  assign pwm_inc = pwm_counter + 8'd1;
  assign pwm_counter_next = (pwm_inc >= cfg_regs.pwm_period) ? '0 : pwm_inc;

  always_comb begin
    if (is_tick) begin
      result.left_motor_on = motor_bits_next[0];
      result.right_motor_on = motor_bits_next[1];
      result.sample_request = adc_fire;
      result.line_state = side_black_next;
      result.left_average = left_average_next;
      result.right_average = right_average_next;
    end else begin
      result.left_motor_on = motor_bits[0];
      result.right_motor_on = motor_bits[1];
      result.sample_request = 1'b0;
      result.line_state = side_black;
      result.left_average = left_average;
      result.right_average = right_average;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AVG_COUNT; i++) begin
        left_ring[i] <= '0;
        right_ring[i] <= '0;
      end
      ring_pointer <= '0;
      adc_tick_count <= '0;
      control_tick_count <= '0;
      pwm_counter <= '0;
      side_black <= lfpc_pkg::SideReset;
      motor_bits <= '0;
      left_average <= '0;
      right_average <= '0;
    end else if (take) begin
      if (is_tick) begin
        adc_tick_count <= adc_tick_count_next;
        control_tick_count <= control_tick_count_next;
        pwm_counter <= pwm_counter_next;
        side_black <= side_black_next;
        motor_bits <= motor_bits_next;
        left_average <= left_average_next;
        right_average <= right_average_next;
      end else begin
        ring_pointer <= ring_pointer_next;
        left_ring[ring_pointer_next] <= item.left_sample;
        right_ring[ring_pointer_next] <= item.right_sample;
      end
    end
  end

endmodule

>>> rtl/lfpc_out_buf.sv
// Two-entry result buffer between the core and the result channel.
module lfpc_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lfpc_pkg::lfpc_result_t push_data,
  output logic                   full,
  lfpc_chan_if.source            result
);

  lfpc_pkg::lfpc_result_t entry [2];
  logic [1:0]             count;
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic                   pop;

  assign pop = result.valid && result.ready;
  assign full = (count == 2'd2);
  assign result.valid = (count != 2'd0);
  assign result.data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/line_follower_pwm_controller.sv
// Line follower PWM controller: top level with configuration registers.
// A result is registered in the result buffer when its request is accepted.
// One request per cycle unless the buffer is full; the core updates at accept.
// A two-entry result buffer lets a new request in while one result waits.
// Reset (rst, synchronous) restores all defaults and empties the result buffer.
module line_follower_pwm_controller #(
  parameter int AVG_COUNT = 4
) (
  input logic       clk,
  input logic       rst,
  lfpc_chan_if.sink cfg,
  lfpc_chan_if.sink item,
  lfpc_chan_if.source result
);

  lfpc_pkg::lfpc_cfg_t    cfg_regs;
  lfpc_pkg::lfpc_result_t core_result;
  logic                   take;
  logic                   full;

  assign cfg.ready = 1'b1;
  assign item.ready = !full;
  assign take = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= lfpc_pkg::CfgReset;
    end else if (cfg.valid) begin
      unique case (lfpc_pkg::lfpc_cfg_idx_t'(cfg.data.index))
        lfpc_pkg::CfgThreshold:     cfg_regs.threshold <= cfg.data.wdata;
        lfpc_pkg::CfgControlPeriod: cfg_regs.control_period <= cfg.data.wdata;
        lfpc_pkg::CfgAdcPeriod:     cfg_regs.adc_period <= cfg.data.wdata;
        lfpc_pkg::CfgPwmPeriod:     cfg_regs.pwm_period <= cfg.data.wdata;
        lfpc_pkg::CfgStraightDuty:  cfg_regs.straight_duty <= cfg.data.wdata;
        lfpc_pkg::CfgFastDuty:      cfg_regs.fast_duty <= cfg.data.wdata;
        lfpc_pkg::CfgSlowDuty:      cfg_regs.slow_duty <= cfg.data.wdata;
        default: ;
      endcase
    end
  end

  lfpc_core #(
    .AVG_COUNT(AVG_COUNT)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .take     (take),
    .item     (item.data),
    .result   (core_result)
  );

  lfpc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (core_result),
    .full      (full),
    .result    (result)
  );

endmodule

>>> tb/lfpc_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the line follower PWM controller: tracks its state per request and compares.
module lfpc_result_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  lfpc_pkg::lfpc_cfg_req_t cfg_req,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  lfpc_pkg::lfpc_item_t   item_req,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  lfpc_pkg::lfpc_result_t result_data,
  output int                     pending,
  output int                     errors
);

  localparam int DataW = lfpc_pkg::DataW;
  localparam int RingDepth = 4;
  localparam int PrintCap = 50;

  lfpc_pkg::lfpc_cfg_t    regs;
  logic [DataW-1:0]       left_ring [RingDepth];
  logic [DataW-1:0]       right_ring [RingDepth];
  int                     ring_ptr;
  int                     adc_count;
  int                     ctrl_count;
  int                     pwm_pos;
  logic [1:0]             black;
  logic [DataW-1:0]       duty_l;
  logic [DataW-1:0]       duty_r;
  logic [1:0]             motors;
  logic [DataW-1:0]       avg_l;
  logic [DataW-1:0]       avg_r;
  lfpc_pkg::lfpc_result_t motor_result_q [$];
  lfpc_pkg::lfpc_result_t predicted;
  lfpc_pkg::lfpc_result_t wanted;
  int                     mismatches = 0;

  function automatic logic [DataW-1:0] floor_mean(input logic [DataW-1:0] ring [RingDepth]);
    int sum;
    sum = 0;
    foreach (ring[i]) sum += ring[i];
    return DataW'(sum / RingDepth);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PrintCap) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic reset_controller();
    regs = lfpc_pkg::CfgReset;
    foreach (left_ring[i]) begin
      left_ring[i] = '0;
      right_ring[i] = '0;
    end
    ring_ptr = 0;
    adc_count = 0;
    ctrl_count = 0;
    pwm_pos = 0;
    black = lfpc_pkg::SideReset;
    duty_l = '0;
    duty_r = '0;
    motors = '0;
    avg_l = '0;
    avg_r = '0;
    motor_result_q.delete();
  endtask

  task automatic apply_reg(input lfpc_pkg::lfpc_cfg_req_t w);
    case (lfpc_pkg::lfpc_cfg_idx_t'(w.index))
      lfpc_pkg::CfgThreshold:     regs.threshold = w.wdata;
      lfpc_pkg::CfgControlPeriod: regs.control_period = w.wdata;
      lfpc_pkg::CfgAdcPeriod:     regs.adc_period = w.wdata;
      lfpc_pkg::CfgPwmPeriod:     regs.pwm_period = w.wdata;
      lfpc_pkg::CfgStraightDuty:  regs.straight_duty = w.wdata;
      lfpc_pkg::CfgFastDuty:      regs.fast_duty = w.wdata;
      lfpc_pkg::CfgSlowDuty:      regs.slow_duty = w.wdata;
      default: ;
    endcase
  endtask

  task automatic step_controller(input lfpc_pkg::lfpc_item_t it,
                                 output lfpc_pkg::lfpc_result_t r);
    logic req;
    req = 1'b0;
    if (it.mode == lfpc_pkg::ModeSample) begin
      ring_ptr = (ring_ptr + 1) % RingDepth;
      left_ring[ring_ptr] = it.left_sample;
      right_ring[ring_ptr] = it.right_sample;
    end else begin
      adc_count++;
      if (adc_count >= regs.adc_period) begin
        req = 1'b1;
        adc_count = 0;
      end
      ctrl_count++;
      if (ctrl_count >= regs.control_period) begin
        avg_l = floor_mean(left_ring);
        avg_r = floor_mean(right_ring);
        // hold the previous classification on a tie
        if (avg_l != regs.threshold && avg_r != regs.threshold)
          black = {avg_r > regs.threshold, avg_l > regs.threshold};
        ctrl_count = 0;
      end
      case (black)
        lfpc_pkg::SideNone: begin
          duty_l = regs.straight_duty;
          duty_r = regs.straight_duty;
        end
        lfpc_pkg::SideLeft: begin
          duty_l = regs.fast_duty;
          duty_r = regs.slow_duty;
        end
        lfpc_pkg::SideRight: begin
          duty_l = regs.slow_duty;
          duty_r = regs.fast_duty;
        end
        default: begin
          duty_l = '0;
          duty_r = '0;
        end
      endcase
      motors = {pwm_pos < duty_r, pwm_pos < duty_l};
      pwm_pos++;
      if (pwm_pos >= regs.pwm_period) pwm_pos = 0;
    end
    r.left_motor_on = motors[0];
    r.right_motor_on = motors[1];
    r.sample_request = req;
    r.line_state = black;
    r.left_average = avg_l;
    r.right_average = avg_r;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_controller();
    end else begin
      if (result_valid && result_ready) begin
        if (motor_result_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          wanted = motor_result_q.pop_front();
          check_field("left_motor_on", result_data.left_motor_on, wanted.left_motor_on);
          check_field("right_motor_on", result_data.right_motor_on, wanted.right_motor_on);
          check_field("sample_request", result_data.sample_request, wanted.sample_request);
          check_field("line_state", result_data.line_state, wanted.line_state);
          check_field("left_average", result_data.left_average, wanted.left_average);
          check_field("right_average", result_data.right_average, wanted.right_average);
        end
      end
      if (item_valid && item_ready) begin
        step_controller(item_req, predicted);
        motor_result_q.push_back(predicted);
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_req);
    end
    pending <= motor_result_q.size();
    errors <= mismatches;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the line follower PWM controller: stimulus, result stalls and verdict.
module testbench;

  localparam int DataW = lfpc_pkg::DataW;
  localparam int PhaseItems = 150;
  localparam int Phases = 8;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 16;

  logic clk;
  logic rst;
  int   pending;
  int   errors;
  int   cycles = 0;
  int   ticks_sent = 0;
  int   samples_sent = 0;
  int   settings_used = 0;

  lfpc_pkg::lfpc_cfg_t active_cfg;
  logic [DataW-1:0]    level_l;
  logic [DataW-1:0]    level_r;

  lfpc_chan_if #(.T(lfpc_pkg::lfpc_cfg_req_t)) cfg_ch ();
  lfpc_chan_if #(.T(lfpc_pkg::lfpc_item_t))    item_ch ();
  lfpc_chan_if #(.T(lfpc_pkg::lfpc_result_t))  result_ch ();

  line_follower_pwm_controller DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  lfpc_result_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_req      (cfg_ch.data),
    .item_valid   (item_ch.valid),
    .item_ready   (item_ch.ready),
    .item_req     (item_ch.data),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .result_data  (result_ch.data),
    .pending      (pending),
    .errors       (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    case ((cycles / 97) % 4)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= ($urandom_range(0, 1) == 0);
      2: result_ch.ready <= (cycles % 4 == 0);
      default: result_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_item(input lfpc_pkg::lfpc_item_t it);
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    do @(posedge clk); while (!item_ch.ready);
    if (it.mode == lfpc_pkg::ModeSample) samples_sent++;
    else ticks_sent++;
  endtask

  task automatic pause_sender(input int n);
    item_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input lfpc_pkg::lfpc_cfg_idx_t idx, input logic [DataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, wdata: value};
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic write_settings(input lfpc_pkg::lfpc_cfg_t c);
    write_reg(lfpc_pkg::CfgThreshold, c.threshold);
    write_reg(lfpc_pkg::CfgControlPeriod, c.control_period);
    write_reg(lfpc_pkg::CfgAdcPeriod, c.adc_period);
    write_reg(lfpc_pkg::CfgPwmPeriod, c.pwm_period);
    write_reg(lfpc_pkg::CfgStraightDuty, c.straight_duty);
    write_reg(lfpc_pkg::CfgFastDuty, c.fast_duty);
    write_reg(lfpc_pkg::CfgSlowDuty, c.slow_duty);
    cfg_ch.valid <= 1'b0;
    active_cfg = c;
    settings_used++;
  endtask

  task automatic send_frame(input logic [DataW-1:0] l, input logic [DataW-1:0] r);
    repeat (4) send_item('{mode: lfpc_pkg::ModeSample, left_sample: l, right_sample: r});
    send_item('{mode: lfpc_pkg::ModeTick, left_sample: '0, right_sample: '0});
  endtask

  function automatic logic [DataW-1:0] pick_byte(input int hi);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return DataW'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic lfpc_pkg::lfpc_cfg_t setting_for_phase(input int phase);
    lfpc_pkg::lfpc_cfg_t c;
    case (phase)
      0: c = '{default: 8'd255};
      1: c = '{threshold: 8'd0, control_period: 8'd1, adc_period: 8'd1, pwm_period: 8'd1,
               straight_duty: 8'd0, fast_duty: 8'd0, slow_duty: 8'd0};
      2: begin
        c = '{default: 8'd0};
        c.threshold = pick_byte(255);
        c.straight_duty = pick_byte(3);
        c.fast_duty = pick_byte(3);
        c.slow_duty = pick_byte(3);
      end
      default: begin
        c.threshold = pick_byte(255);
        c.control_period = ($urandom_range(0, 7) == 0) ? pick_byte(255)
                                                         : DataW'($urandom_range(1, 8));
        c.adc_period = ($urandom_range(0, 7) == 0) ? pick_byte(255)
                                                     : DataW'($urandom_range(1, 6));
        c.pwm_period = ($urandom_range(0, 5) == 0) ? pick_byte(255)
                                                     : DataW'($urandom_range(1, 16));
        c.straight_duty = pick_byte(20);
        c.fast_duty = pick_byte(20);
        c.slow_duty = pick_byte(20);
      end
    endcase
    return c;
  endfunction

  function automatic logic [DataW-1:0] pick_level();
    case ($urandom_range(0, 5))
      0: return active_cfg.threshold;
      1: return active_cfg.threshold + 8'd1;
      2: return active_cfg.threshold - 8'd1;
      3: return '0;
      4: return '1;
      default: return DataW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [DataW-1:0] sample_near(input logic [DataW-1:0] level);
    case ($urandom_range(0, 9))
      6: return level + 8'd1;
      7: return level - 8'd1;
      8, 9: return DataW'($urandom_range(0, 255));
      default: return level;
    endcase
  endfunction

  task automatic run_random_phase();
    lfpc_pkg::lfpc_item_t it;
    int sent;
    int burst;
    sent = 0;
    while (sent < PhaseItems) begin
      burst = $urandom_range(1, 24);
      if ($urandom_range(0, 1) == 0) level_l = pick_level();
      if ($urandom_range(0, 1) == 0) level_r = pick_level();
      repeat (burst) begin
        it.mode = ($urandom_range(0, 9) < 4) ? lfpc_pkg::ModeSample : lfpc_pkg::ModeTick;
        it.left_sample = sample_near(level_l);
        it.right_sample = sample_near(level_r);
        send_item(it);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.data <= '0;
    active_cfg = lfpc_pkg::CfgReset;
    level_l = '0;
    level_r = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state: both sides black, duties zero
    repeat (2) send_item('{mode: lfpc_pkg::ModeTick, left_sample: '0, right_sample: '0});
    drain_results();
    write_settings('{threshold: 8'd100, control_period: 8'd1, adc_period: 8'd1,
                     pwm_period: 8'd3, straight_duty: 8'd255, fast_duty: 8'd2,
                     slow_duty: 8'd1});
    send_frame(8'd255, 8'd0);
    send_frame(8'd0, 8'd255);
    send_frame(8'd0, 8'd0);
    send_frame(8'd255, 8'd255);
    // left average on the threshold: keep both sides black
    send_frame(8'd100, 8'd255);
    drain_results();

    for (int p = 0; p < Phases; p++) begin
      write_settings(setting_for_phase(p));
      run_random_phase();
      drain_results();
    end

    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d requests: %0d ticks and %0d sample pairs",
             ticks_sent + samples_sent, ticks_sent, samples_sent);
    $display("over %0d register settings incl. all-max, all-min and zero periods, with stalls",
             settings_used);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
